FILE: rtl/bdq_pkg.sv
// shared constants, codes and types of the bounded deque engine
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);

    // operation codes
    localparam logic [3:0] FN_CREATE  = 4'd0;
    localparam logic [3:0] FN_PUSH_F  = 4'd1;
    localparam logic [3:0] FN_PUSH_B  = 4'd2;
    localparam logic [3:0] FN_INSERT  = 4'd3;
    localparam logic [3:0] FN_POP_F   = 4'd4;
    localparam logic [3:0] FN_POP_B   = 4'd5;
    localparam logic [3:0] FN_DELETE  = 4'd6;
    localparam logic [3:0] FN_REVERSE = 4'd7;
    localparam logic [3:0] FN_DUMP    = 4'd8;
    localparam logic [3:0] FN_DESTROY = 4'd9;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOLIST = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_NOKEY  = 3'd4;
    localparam logic [2:0] ST_SINGLE = 3'd5;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [31:0]   wdata;
        logic [AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic          present;
        logic [CW-1:0] count;
        logic          busy;
    } t_stat;

endpackage

FILE: rtl/bdq_if.sv
// handshake channels of the bounded deque engine

interface bdq_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic signed [31:0] key_in;

    modport source (output valid, output func, output key_in, input ready);
    modport sink (input valid, input func, input key_in, output ready);
endinterface

interface bdq_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] key_out;
    logic [3:0]         position;
    logic               last;

    modport source (output valid, output status, output key_out, output position,
                    output last, input ready);
    modport sink (input valid, input status, input key_out, input position,
                  input last, output ready);
endinterface

FILE: rtl/bdq_ram.sv
// generic ram, one write port and one registered read port
module bdq_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/bdq_core.sv
// sequencer of the deque engine: decode, search, shift, dump and result register
module bdq_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bdq_in_if.sink            i_in,
    bdq_out_if.source         o_out,
    output bdq_pkg::t_mem_req o_mem,
    input  logic [31:0]       i_rdata,
    output bdq_pkg::t_stat    o_stat
);
    import bdq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_SHU_RD, S_SHU_WR, S_PUT, S_RM_RD, S_RM_DAT,
        S_SHD_RD, S_SHD_WR, S_DMP_RD, S_DMP_OUT, S_RESP
    } t_state;

    t_state        r_state;
    logic          r_present;
    logic          r_rev;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_j;
    logic [3:0]    r_func;
    logic [31:0]   r_key;
    logic [2:0]    r_rst;
    logic [31:0]   r_rkey;
    logic          r_ov;
    logic [2:0]    r_ost;
    logic [31:0]   r_okey;
    logic [3:0]    r_opos;
    logic          r_olast;
    logic          w_ofree;
    logic          w_oload;
    logic [CW-1:0] w_phys;
    logic [CW-1:0] w_jm1;
    logic [CW-1:0] w_jp1;

    // storage place of a list index, the list may be held back to front
    function automatic logic [CW-1:0] f_phys(input logic rev, input logic [CW-1:0] cnt,
                                             input logic [CW-1:0] i);
        return rev ? (cnt - i - CW'(1)) : i;
    endfunction

    // storage slot opened by an insert before list index i
    function automatic logic [CW-1:0] f_ins(input logic rev, input logic [CW-1:0] cnt,
                                            input logic [CW-1:0] i);
        return rev ? (cnt - i) : i;
    endfunction

    assign w_ofree = !r_ov || o_out.ready;
    assign w_oload = ((r_state == S_DMP_OUT) || (r_state == S_RESP)) && w_ofree;

    // addresses next to the current walk position
    assign w_phys = f_phys(r_rev, r_count, r_idx);
    assign w_jm1  = r_j - CW'(1);
    assign w_jp1  = r_j + CW'(1);

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.status   = r_ost;
    assign o_out.key_out  = r_okey;
    assign o_out.position = r_opos;
    assign o_out.last     = r_olast;

    assign o_stat.present = r_present;
    assign o_stat.count   = r_count;
    assign o_stat.busy    = (r_state != S_IDLE);

    // memory port selection
    always_comb begin
        o_mem.we    = 1'b0;
        o_mem.waddr = r_j[AW-1:0];
        o_mem.wdata = i_rdata;
        o_mem.raddr = '0;
        case (r_state)
            S_SRCH_RD, S_DMP_RD, S_DMP_OUT: o_mem.raddr = w_phys[AW-1:0];
            S_SHU_RD: o_mem.raddr = w_jm1[AW-1:0];
            S_SHU_WR, S_SHD_WR: o_mem.we = 1'b1;
            S_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pos[AW-1:0];
                o_mem.wdata = r_key;
            end
            S_RM_RD: o_mem.raddr = r_pos[AW-1:0];
            S_SHD_RD: o_mem.raddr = w_jp1[AW-1:0];
            default: o_mem.raddr = '0;
        endcase
    end

    // state, list bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= 1'b0;
            r_rev     <= 1'b0;
            r_count   <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (w_oload) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func  <= i_in.func;
                        r_key   <= i_in.key_in;
                        r_idx   <= '0;
                        r_j     <= r_count;
                        r_rst   <= ST_OK;
                        r_rkey  <= '0;
                        r_state <= S_RESP;
                        if (i_in.func > FN_DESTROY) begin
                            r_rst <= ST_OK;
                        end else if (i_in.func == FN_CREATE) begin
                            r_present <= 1'b1;
                            r_count   <= '0;
                            r_rev     <= 1'b0;
                        end else if (!r_present) begin
                            r_rst <= ST_NOLIST;
                        end else begin
                            case (i_in.func)
                                FN_PUSH_F, FN_PUSH_B, FN_INSERT: begin
                                    if (r_count == CW'(CAPACITY)) begin
                                        r_rst <= ST_FULL;
                                    end else if (i_in.func == FN_PUSH_F) begin
                                        r_pos   <= f_ins(r_rev, r_count, '0);
                                        r_state <= S_SHU_RD;
                                    end else if (i_in.func == FN_PUSH_B
                                                 || r_count == '0) begin
                                        r_pos   <= f_ins(r_rev, r_count, r_count);
                                        r_state <= S_SHU_RD;
                                    end else begin
                                        r_state <= S_SRCH_RD;
                                    end
                                end
                                FN_POP_F, FN_POP_B: begin
                                    if (r_count == '0) begin
                                        r_rst <= ST_EMPTY;
                                    end else begin
                                        r_pos <= f_phys(r_rev, r_count,
                                                        (i_in.func == FN_POP_F) ? '0
                                                        : r_count - CW'(1));
                                        r_state <= S_RM_RD;
                                    end
                                end
                                FN_DELETE: begin
                                    if (r_count == '0) begin
                                        r_rst <= ST_EMPTY;
                                    end else begin
                                        r_state <= S_SRCH_RD;
                                    end
                                end
                                FN_REVERSE: begin
                                    if (r_count == '0) begin
                                        r_rst <= ST_EMPTY;
                                    end else if (r_count == CW'(1)) begin
                                        r_rst <= ST_SINGLE;
                                    end else begin
                                        r_rev <= !r_rev;
                                    end
                                end
                                FN_DUMP: begin
                                    if (r_count == '0) begin
                                        r_rst <= ST_EMPTY;
                                    end else begin
                                        r_state <= S_DMP_RD;
                                    end
                                end
                                default: begin
                                    r_present <= 1'b0;
                                    r_count   <= '0;
                                    r_rev     <= 1'b0;
                                end
                            endcase
                        end
                    end
                end
                S_SRCH_RD: r_state <= S_SRCH_CMP;
                // compare one stored key per visit
                S_SRCH_CMP: begin
                    if (r_func == FN_INSERT) begin
                        if ($signed(i_rdata) > $signed(r_key)) begin
                            r_pos   <= f_ins(r_rev, r_count, r_idx);
                            r_state <= S_SHU_RD;
                        end else if (r_idx == r_count - CW'(1)) begin
                            r_pos   <= f_ins(r_rev, r_count, r_count);
                            r_state <= S_SHU_RD;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_SRCH_RD;
                        end
                    end else begin
                        if (i_rdata == r_key) begin
                            r_rkey  <= i_rdata;
                            r_j     <= f_phys(r_rev, r_count, r_idx);
                            r_state <= S_SHD_RD;
                        end else if (r_idx == r_count - CW'(1)) begin
                            r_rst   <= ST_NOKEY;
                            r_state <= S_RESP;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_SRCH_RD;
                        end
                    end
                end
                // open a slot by moving entries up
                S_SHU_RD: r_state <= (r_j > r_pos) ? S_SHU_WR : S_PUT;
                S_SHU_WR: begin
                    r_j     <= r_j - CW'(1);
                    r_state <= S_SHU_RD;
                end
                S_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_RESP;
                end
                // fetch the removed key
                S_RM_RD: r_state <= S_RM_DAT;
                S_RM_DAT: begin
                    r_rkey  <= i_rdata;
                    r_j     <= r_pos;
                    r_state <= S_SHD_RD;
                end
                // close the gap by moving entries down
                S_SHD_RD: begin
                    if (r_j + CW'(1) < r_count) begin
                        r_state <= S_SHD_WR;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_RESP;
                    end
                end
                S_SHD_WR: begin
                    r_j     <= r_j + CW'(1);
                    r_state <= S_SHD_RD;
                end
                // dump one word per stored key
                S_DMP_RD: r_state <= S_DMP_OUT;
                S_DMP_OUT: begin
                    if (w_ofree) begin
                        r_ost   <= ST_OK;
                        r_okey  <= i_rdata;
                        r_opos  <= 4'(r_idx);
                        r_olast <= (r_idx == r_count - CW'(1));
                        if (r_idx == r_count - CW'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_DMP_RD;
                        end
                    end
                end
                S_RESP: begin
                    if (w_ofree) begin
                        r_ost   <= r_rst;
                        r_okey  <= r_rkey;
                        r_opos  <= '0;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/bounded_deque_sorted_list_engine_unit.sv
// top level of the bounded deque and sorted list engine
// Usage:
//   i_in carries one command word (func, key_in); o_out returns result words
//   (status, key_out, position, last). A word moves when valid and ready are high.
//   Keys sit in one ram of CAPACITY entries; a reverse only flips the read order.
// Command steps:
//   create, destroy, reverse, errors and unknown codes: straight to the result.
//   push front/back: a read and a write per entry moved to open the slot, then
//   the key is written. pop: the removed key is read, then a read and a write
//   per entry moved to close the gap. Sorted insert and delete first read and
//   compare stored keys before the shift. dump: a read and a result word per key.
//   Each step makes one access of the ram read port. A new command is taken once
//   the previous one is finished.
// Reset: no list exists, count is zero; ram contents are not cleared and
//   are never read before written.
// Stall: a finished word waits in the output register; the engine stops while that
//   register is full and not taken by ready, and it needs to place another word.
module bounded_deque_sorted_list_engine_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdq_in_if.sink    i_in,
    bdq_out_if.source o_out
);
    import bdq_pkg::*;

    t_mem_req    w_mem;
    t_stat       w_stat;
    logic [31:0] w_rdata;

    // command sequencer
    bdq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_mem   (w_mem),
        .i_rdata (w_rdata),
        .o_stat  (w_stat)
    );

    // key storage
    bdq_ram #(.W(32), .D(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_nolist_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_stat.present |-> w_stat.count == '0)
        else $error("elements held with no list");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> w_stat.busy)
        else $error("accepted word did not start work");
`endif
endmodule
